// ----- hw/rtl/bvop_pkg.sv -----
// Shared types and constants for the BOOTP vendor option parser.
`timescale 1ns / 1ps

package bvop_pkg;

   localparam int VEND_BYTES_DEF  = 64;
   localparam int NAME_LIMIT_DEF  = 79;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [31:0] MAGIC_COOKIE_RESET = 32'h6382_5363;

   // result kinds
   localparam logic [2:0] KIND_OWN_ADDR = 3'd0;
   localparam logic [2:0] KIND_MASK     = 3'd1;
   localparam logic [2:0] KIND_GATEWAY  = 3'd2;
   localparam logic [2:0] KIND_SERVER   = 3'd3;
   localparam logic [2:0] KIND_NAME     = 3'd4;
   localparam logic [2:0] KIND_DONE     = 3'd5;

   // bits of entry_type.present, in output order
   localparam int PIECE_DATA     = 0;
   localparam int PIECE_FALLBACK = 1;
   localparam int PIECE_DONE     = 2;

   // One queued command: up to three results caused by one transaction.
   typedef struct packed {
      logic [2:0]  present;
      logic [2:0]  kind;
      logic [31:0] value;
      logic [7:0]  index;
      logic [31:0] relay;
      logic [1:0]  flags;
   } entry_type;

endpackage

// ----- hw/rtl/bvop_fifo.sv -----
// Small flop-based queue between the parser front and the result back end.
`timescale 1ns / 1ps

module bvop_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/bvop_front.sv -----
// Parser front: per-transaction option state machine, builds queue entries.
`timescale 1ns / 1ps

module bvop_front #(
   parameter int VEND_BYTES = bvop_pkg::VEND_BYTES_DEF,
   parameter int NAME_LIMIT = bvop_pkg::NAME_LIMIT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [31:0]         csr_wdata,
   input  logic                item_accept,
   input  logic                op,
   input  logic [31:0]         your_ip,
   input  logic [31:0]         relay_gateway_ip,
   input  logic [7:0]          vend_byte,
   input  logic                last_byte,
   output logic                push_valid,
   output bvop_pkg::entry_type push_entry
);

   localparam int POS_W = $clog2(VEND_BYTES + 1);

   localparam logic OP_START = 1'b0;

   localparam logic [2:0] PH_COOKIE = 3'd0;
   localparam logic [2:0] PH_TAG    = 3'd1;
   localparam logic [2:0] PH_LEN    = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_STOP   = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;

   localparam logic [7:0] TAG_PAD     = 8'd0;
   localparam logic [7:0] TAG_MASK    = 8'd1;
   localparam logic [7:0] TAG_GATEWAY = 8'd3;
   localparam logic [7:0] TAG_SERVER  = 8'd6;
   localparam logic [7:0] TAG_HOST    = 8'd12;
   localparam logic [7:0] TAG_END     = 8'd255;

   localparam int COOKIE_BYTES = 4;

   logic [31:0]      cookie_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [2:0]       phase_ff, phase_in;
   logic [7:0]       tag_ff, tag_in;
   logic [7:0]       left_ff, left_in;
   logic [31:0]      acc_ff, acc_in;
   logic [2:0]       wbc_ff, wbc_in;
   logic [7:0]       gw_cnt_ff, gw_cnt_in;
   logic [7:0]       ns_cnt_ff, ns_cnt_in;
   logic [7:0]       name_cnt_ff, name_cnt_in;
   logic [1:0]       flags_ff, flags_in;
   logic [31:0]      relay_ff, relay_in;
   logic [31:0]      acc_shift;
   logic [2:0]       wbc_inc;

   bvop_pkg::entry_type entry;

   assign acc_shift = {acc_ff[23:0], vend_byte};
   assign wbc_inc   = wbc_ff + 3'd1;

   always_comb begin
      pos_in      = pos_ff;
      phase_in    = phase_ff;
      tag_in      = tag_ff;
      left_in     = left_ff;
      acc_in      = acc_ff;
      wbc_in      = wbc_ff;
      gw_cnt_in   = gw_cnt_ff;
      ns_cnt_in   = ns_cnt_ff;
      name_cnt_in = name_cnt_ff;
      flags_in    = flags_ff;
      relay_in    = relay_ff;
      entry       = '0;

      if (op == OP_START) begin
         pos_in              = '0;
         phase_in            = PH_COOKIE;
         tag_in              = '0;
         left_in             = '0;
         acc_in              = '0;
         wbc_in              = '0;
         gw_cnt_in           = '0;
         ns_cnt_in           = '0;
         name_cnt_in         = '0;
         flags_in            = '0;
         relay_in            = relay_gateway_ip;
         entry.present[bvop_pkg::PIECE_DATA] = 1'b1;
         entry.kind          = bvop_pkg::KIND_OWN_ADDR;
         entry.value         = your_ip;
      end else if (phase_ff != PH_DONE) begin
         if (pos_ff < POS_W'(VEND_BYTES)) begin
            pos_in = pos_ff + 1'b1;
            case (phase_ff)
               PH_COOKIE: begin
                  acc_in = acc_shift;
                  if (pos_ff == POS_W'(COOKIE_BYTES - 1)) begin
                     phase_in = (acc_shift == cookie_ff) ? PH_TAG : PH_STOP;
                     acc_in   = '0;
                  end
               end
               PH_TAG: begin
                  if (vend_byte == TAG_END) begin
                     phase_in = PH_STOP;
                  end else if (vend_byte != TAG_PAD) begin
                     tag_in   = vend_byte;
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  left_in = vend_byte;
                  wbc_in  = '0;
                  acc_in  = '0;
                  if (tag_ff == TAG_SERVER) begin
                     flags_in[1] = 1'b1;
                  end
                  phase_in = (vend_byte == 8'd0) ? PH_TAG : PH_DATA;
               end
               PH_DATA: begin
                  left_in = left_ff - 8'd1;
                  if (tag_ff == TAG_MASK) begin
                     // only the first four bytes count; a short mask never emits
                     if (wbc_ff < 3'd4) begin
                        acc_in = acc_shift;
                        wbc_in = wbc_inc;
                        if (wbc_inc == 3'd4) begin
                           entry.present[bvop_pkg::PIECE_DATA] = 1'b1;
                           entry.kind  = bvop_pkg::KIND_MASK;
                           entry.value = acc_shift;
                           flags_in[0] = 1'b1;
                        end
                     end
                  end else if (tag_ff == TAG_GATEWAY || tag_ff == TAG_SERVER) begin
                     acc_in = acc_shift;
                     wbc_in = wbc_inc;
                     if (wbc_inc >= 3'd4) begin
                        wbc_in = '0;
                        entry.present[bvop_pkg::PIECE_DATA] = 1'b1;
                        entry.value = acc_shift;
                        if (tag_ff == TAG_GATEWAY) begin
                           if (gw_cnt_ff != 8'd255) begin
                              gw_cnt_in = gw_cnt_ff + 8'd1;
                           end
                           entry.kind  = bvop_pkg::KIND_GATEWAY;
                           entry.index = gw_cnt_in;
                        end else begin
                           if (ns_cnt_ff != 8'd255) begin
                              ns_cnt_in = ns_cnt_ff + 8'd1;
                           end
                           entry.kind  = bvop_pkg::KIND_SERVER;
                           entry.index = ns_cnt_in;
                        end
                     end
                  end else if (tag_ff == TAG_HOST) begin
                     // a zero byte ends the name for the rest of the reply
                     if (vend_byte == 8'd0) begin
                        name_cnt_in = 8'd255;
                     end else if (name_cnt_ff < 8'(NAME_LIMIT)) begin
                        name_cnt_in = name_cnt_ff + 8'd1;
                        entry.present[bvop_pkg::PIECE_DATA] = 1'b1;
                        entry.kind  = bvop_pkg::KIND_NAME;
                        entry.value = {24'd0, vend_byte};
                     end
                  end
                  if (left_in == 8'd0) begin
                     phase_in = PH_TAG;
                  end
               end
               default: begin
               end
            endcase
         end
         if (last_byte) begin
            entry.present[bvop_pkg::PIECE_FALLBACK] = (gw_cnt_in == 8'd0);
            entry.present[bvop_pkg::PIECE_DONE]     = 1'b1;
            entry.relay = relay_ff;
            entry.flags = flags_in;
            phase_in    = PH_DONE;
         end
      end
   end

   assign push_valid = item_accept && (entry.present != '0);
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         cookie_ff <= bvop_pkg::MAGIC_COOKIE_RESET;
      end else if (csr_we) begin
         cookie_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         phase_ff    <= PH_COOKIE;
         tag_ff      <= '0;
         left_ff     <= '0;
         acc_ff      <= '0;
         wbc_ff      <= '0;
         gw_cnt_ff   <= '0;
         ns_cnt_ff   <= '0;
         name_cnt_ff <= '0;
         flags_ff    <= '0;
         relay_ff    <= '0;
      end else if (item_accept) begin
         pos_ff      <= pos_in;
         phase_ff    <= phase_in;
         tag_ff      <= tag_in;
         left_ff     <= left_in;
         acc_ff      <= acc_in;
         wbc_ff      <= wbc_in;
         gw_cnt_ff   <= gw_cnt_in;
         ns_cnt_ff   <= ns_cnt_in;
         name_cnt_ff <= name_cnt_in;
         flags_ff    <= flags_in;
         relay_ff    <= relay_in;
      end
   end

endmodule

// ----- hw/rtl/bvop_back.sv -----
// Result back end: unpacks queue entries into single results on the output register.
`timescale 1ns / 1ps

module bvop_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  bvop_pkg::entry_type pop_entry,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [39:0]         rsp_tdata,
   output logic                rsp_tlast,
   output logic [2:0]          rsp_tuser
);

   logic        valid_ff, valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic [31:0] value_ff, value_in;
   logic [7:0]  index_ff, index_in;
   logic        last_ff, last_in;
   logic [2:0]  used_ff, used_in;
   logic [2:0]  remaining;
   logic [2:0]  sel;
   logic        load;
   logic        final_piece;

   assign remaining   = pop_entry.present & ~used_ff;
   assign sel         = remaining & (~remaining + 3'd1);
   assign final_piece = ((remaining & ~sel) == 3'd0);
   assign load        = pop_valid && (!valid_ff || rsp_tready);
   assign pop_ready   = load && final_piece;

   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      value_in = value_ff;
      index_in = index_ff;
      last_in  = last_ff;
      used_in  = used_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         last_in  = final_piece;
         used_in  = final_piece ? 3'd0 : (used_ff | sel);
         if (sel[bvop_pkg::PIECE_DATA]) begin
            kind_in  = pop_entry.kind;
            value_in = pop_entry.value;
            index_in = pop_entry.index;
         end else if (sel[bvop_pkg::PIECE_FALLBACK]) begin
            kind_in  = bvop_pkg::KIND_GATEWAY;
            value_in = pop_entry.relay;
            index_in = 8'd1;
         end else begin
            kind_in  = bvop_pkg::KIND_DONE;
            value_in = {30'd0, pop_entry.flags};
            index_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         used_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      index_ff <= index_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {index_ff, value_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = kind_ff;

endmodule

// ----- hw/rtl/bootp_vendor_option_parser_top.sv -----
// Top level of the BOOTP vendor option parser.
`timescale 1ns / 1ps

// Parses one BOOTP reply per run. The req channel carries a start transaction
// (tuser 0) with the assigned and relay gateway addresses, then vendor bytes
// (tuser 1) one per transaction, tlast on the final byte of the reply.
// The rsp channel returns results: own address, subnet mask, numbered
// gateways and name servers, host name characters and a closing done item
// with flags. tlast marks the last result caused by one req transaction.
// csr_we/csr_wdata load the expected magic cookie; write only while idle.
// A result is held in the queue and then in the output register. The front
// takes one transaction per cycle while the queue has room; the back end
// drives one result per cycle while rsp_tready is high. The QUEUE_DEPTH-entry
// queue absorbs the up to three results of a closing byte (data, fallback, done).
// When rsp_tready is low the queue fills and req_tready drops once it is full.
// Reset (synchronous) empties the queue, clears the parse state as for a
// reply with relay gateway zero and restores the default magic cookie.

module bootp_vendor_option_parser_top #(
   parameter int VEND_BYTES  = bvop_pkg::VEND_BYTES_DEF,
   parameter int NAME_LIMIT  = bvop_pkg::NAME_LIMIT_DEF,
   parameter int QUEUE_DEPTH = bvop_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // your_ip, relay_gateway_ip, vend_byte
   input  logic        req_tlast,   // last_byte
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // value, index
   output logic        rsp_tlast,   // last result of one req transaction
   output logic [2:0]  rsp_tuser    // kind
);

   localparam int ENTRY_W = $bits(bvop_pkg::entry_type);

   logic                item_accept;
   logic                push_valid;
   logic                push_ready;
   logic                pop_valid;
   logic                pop_ready;
   bvop_pkg::entry_type push_entry;
   bvop_pkg::entry_type pop_entry;

   assign req_tready  = push_ready;
   assign item_accept = req_tvalid && req_tready;

   bvop_front #(
      .VEND_BYTES (VEND_BYTES),
      .NAME_LIMIT (NAME_LIMIT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .item_accept      (item_accept),
      .op               (req_tuser),
      .your_ip          (req_tdata[31:0]),
      .relay_gateway_ip (req_tdata[63:32]),
      .vend_byte        (req_tdata[71:64]),
      .last_byte        (req_tlast),
      .push_valid       (push_valid),
      .push_entry       (push_entry)
   );

   bvop_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_entry)
   );

   bvop_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef NO_ASSERTIONS
   // the front only queues work for a transaction it accepted, so never into a full queue
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("queue push while full");

   a_done_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == bvop_pkg::KIND_DONE) |-> rsp_tlast)
      else $error("done result without end of run");

   a_own_addr_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == bvop_pkg::KIND_OWN_ADDR) |->
      (rsp_tlast && rsp_tdata[39:32] == 8'd0))
      else $error("own address result malformed");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= bvop_pkg::KIND_DONE))
      else $error("result kind out of range");
`endif

endmodule
